// ===== hdl/a85dec_pkg.sv =====
// Shared types, codes, character constants and digit weights for the Ascii85 decoder.
package a85dec_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_START_HDR  = 3'd0,
    PH_START      = 3'd1,
    PH_IN_GROUP   = 3'd2,
    PH_WANT_TILDE = 3'd3,
    PH_WANT_GT    = 3'd4,
    PH_ERROR      = 3'd5
  } phase_t;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_TILDE   = 3'd1;
  localparam logic [2:0] ST_Z_INSIDE   = 3'd2;
  localparam logic [2:0] ST_Y_INSIDE   = 3'd3;
  localparam logic [2:0] ST_NO_GT      = 3'd4;
  localparam logic [2:0] ST_BAD_DIGIT  = 3'd5;
  localparam logic [2:0] ST_SHORT_ONE  = 3'd6;

  // Characters of interest
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FIRST = 8'h21;
  localparam logic [7:0] CH_LAST  = 8'h75;

  localparam logic [31:0] SPACES4 = 32'h2020_2020;

  // One decoded result travelling from the core to the output register
  typedef struct packed {
    logic        hit;
    logic [31:0] data;
    logic [2:0]  count;
    logic [2:0]  status;
  } result_t;

  // Weight of the digit at a given place in a group (first digit weighs 85^4)
  function automatic logic [31:0] weight85(input logic [2:0] place);
    logic [31:0] w;
    unique case (place)
      3'd0:    w = 32'd52200625;
      3'd1:    w = 32'd614125;
      3'd2:    w = 32'd7225;
      3'd3:    w = 32'd85;
      3'd4:    w = 32'd1;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/ascii85_stream_decoder.sv =====
// Top level of the Ascii85 stream decoder: input register, decode core, result register.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------
//  in      | in_valid, in_stall | character, end_of_input
//  out     | out_valid, out_stall | data_bytes, byte_count, status
//
// One character per cycle while the output is not stalled; each item passes from the
// input register to the result register; one that yields no result leaves no output.
// The single decode step (one constant multiply and an add) sets the rate.
// Reset clears the state to a group start with the header allowed; no clearing pass.
// A stall on the output holds both registers; the input stalls only while its
// register is full and cannot move on.
module ascii85_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] data_bytes,
  output logic [2:0]  byte_count,
  output logic [2:0]  status
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eoi;
  logic       adv;
  a85dec_pkg::result_t res;

  // Pipeline moves when the result register is empty or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_valid || adv) begin
      s1_char <= character;
      s1_eoi  <= end_of_input;
    end
  end

  a85dec_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (s1_valid && adv),
    .ch   (s1_char),
    .eoi  (s1_eoi),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_bytes <= res.data;
      byte_count <= res.count;
      status     <= res.status;
    end
  end

endmodule

// ===== hdl/a85dec_core.sv =====
// Decoder state and the per-character decode logic.
module a85dec_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           ch,
  input  logic                 eoi,
  output a85dec_pkg::result_t  res
);

  a85dec_pkg::phase_t phase, phase_next;
  logic [31:0] acc, acc_next;
  logic [2:0]  cnt, cnt_next;

  logic [2:0]  cnt_c;
  logic [6:0]  digit_val;
  logic [31:0] prod;
  logic [31:0] acc_add;
  logic [31:0] fl_sum;
  logic [31:0] fl_mask;
  logic        is_digit;

  // Digit datapath: value times place weight, added into the group sum
  assign cnt_c     = (cnt > 3'd4) ? 3'd4 : cnt;
  assign digit_val = 7'(ch - a85dec_pkg::CH_FIRST);
  assign prod      = 32'(digit_val) * a85dec_pkg::weight85(cnt_c);
  assign acc_add   = acc + prod;
  assign is_digit  = (ch >= a85dec_pkg::CH_FIRST) && (ch <= a85dec_pkg::CH_LAST);

  // Short-group flush: pad with the next power of 85, keep the leading bytes
  assign fl_sum = acc + a85dec_pkg::weight85(3'(cnt - 3'd1));
  always_comb begin
    unique case (cnt)
      3'd2:    fl_mask = 32'hFF00_0000;
      3'd3:    fl_mask = 32'hFFFF_0000;
      3'd4:    fl_mask = 32'hFFFF_FF00;
      default: fl_mask = 32'h0000_0000;
    endcase
  end

  // Next state and result
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    cnt_next   = cnt;
    res        = '0;
    if (step) begin
      if (eoi) begin
        if (phase == a85dec_pkg::PH_WANT_TILDE) begin
          res.hit    = 1'b1;
          res.status = a85dec_pkg::ST_NO_TILDE;
        end else if (phase == a85dec_pkg::PH_WANT_GT) begin
          res.hit    = 1'b1;
          res.status = a85dec_pkg::ST_NO_GT;
        end else if (phase == a85dec_pkg::PH_START_HDR || phase == a85dec_pkg::PH_START ||
                     phase == a85dec_pkg::PH_IN_GROUP) begin
          if (cnt == 3'd1) begin
            res.hit    = 1'b1;
            res.status = a85dec_pkg::ST_SHORT_ONE;
          end else if (cnt != 3'd0) begin
            res.hit   = 1'b1;
            res.data  = fl_sum & fl_mask;
            res.count = (cnt_c - 3'd1);
          end
        end
        // End of input always rearms the stream
        phase_next = a85dec_pkg::PH_START_HDR;
        acc_next   = '0;
        cnt_next   = '0;
      end else begin
        unique case (phase)
          a85dec_pkg::PH_WANT_TILDE: begin
            if (ch != a85dec_pkg::CH_TILDE) begin
              res.hit    = 1'b1;
              res.status = a85dec_pkg::ST_NO_TILDE;
              phase_next = a85dec_pkg::PH_ERROR;
              acc_next   = '0;
              cnt_next   = '0;
            end else begin
              phase_next = a85dec_pkg::PH_START;
            end
          end
          a85dec_pkg::PH_WANT_GT: begin
            acc_next = '0;
            cnt_next = '0;
            if (ch != a85dec_pkg::CH_GT) begin
              res.hit    = 1'b1;
              res.status = a85dec_pkg::ST_NO_GT;
              phase_next = a85dec_pkg::PH_ERROR;
            end else if (cnt == 3'd1) begin
              res.hit    = 1'b1;
              res.status = a85dec_pkg::ST_SHORT_ONE;
              phase_next = a85dec_pkg::PH_ERROR;
            end else begin
              phase_next = a85dec_pkg::PH_START;
              if (cnt != 3'd0) begin
                res.hit   = 1'b1;
                res.data  = fl_sum & fl_mask;
                res.count = (cnt_c - 3'd1);
              end
            end
          end
          a85dec_pkg::PH_START_HDR, a85dec_pkg::PH_START, a85dec_pkg::PH_IN_GROUP: begin
            priority if (cnt == 3'd0 && phase == a85dec_pkg::PH_START_HDR &&
                         ch == a85dec_pkg::CH_LT) begin
              phase_next = a85dec_pkg::PH_WANT_TILDE;
            end else if (cnt == 3'd0 &&
                         (ch == a85dec_pkg::CH_CR || ch == a85dec_pkg::CH_LF)) begin
              // line breaks between groups are skipped
            end else if (cnt == 3'd0 && ch == a85dec_pkg::CH_Z) begin
              res.hit    = 1'b1;
              res.count  = 3'd4;
              phase_next = a85dec_pkg::PH_START;
            end else if (cnt == 3'd0 && ch == a85dec_pkg::CH_Y) begin
              res.hit    = 1'b1;
              res.data   = a85dec_pkg::SPACES4;
              res.count  = 3'd4;
              phase_next = a85dec_pkg::PH_START;
            end else if (cnt != 3'd0 && ch == a85dec_pkg::CH_Z) begin
              res.hit    = 1'b1;
              res.status = a85dec_pkg::ST_Z_INSIDE;
              phase_next = a85dec_pkg::PH_ERROR;
              acc_next   = '0;
              cnt_next   = '0;
            end else if (cnt != 3'd0 && ch == a85dec_pkg::CH_Y) begin
              res.hit    = 1'b1;
              res.status = a85dec_pkg::ST_Y_INSIDE;
              phase_next = a85dec_pkg::PH_ERROR;
              acc_next   = '0;
              cnt_next   = '0;
            end else if (ch == a85dec_pkg::CH_TILDE) begin
              phase_next = a85dec_pkg::PH_WANT_GT;
            end else if (!is_digit) begin
              res.hit    = 1'b1;
              res.status = a85dec_pkg::ST_BAD_DIGIT;
              phase_next = a85dec_pkg::PH_ERROR;
              acc_next   = '0;
              cnt_next   = '0;
            end else if (cnt_c == 3'd4) begin
              // fifth digit completes the group
              res.hit    = 1'b1;
              res.data   = acc_add;
              res.count  = 3'd4;
              phase_next = a85dec_pkg::PH_START;
              acc_next   = '0;
              cnt_next   = '0;
            end else begin
              acc_next   = acc_add;
              cnt_next   = cnt_c + 3'd1;
              phase_next = a85dec_pkg::PH_IN_GROUP;
            end
          end
          default: begin
            // error: characters are dropped until end of input
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= a85dec_pkg::PH_START_HDR;
      acc   <= '0;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      acc   <= acc_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== hdl/a85dec_checker.sv =====
// Port-level checks for the Ascii85 stream decoder, bound to the top level.
module a85dec_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  character,
  input logic        end_of_input,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] data_bytes,
  input logic [2:0]  byte_count,
  input logic [2:0]  status
);

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(character) && $stable(end_of_input))
    else $error("input item changed while stalled");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_bytes) &&
    $stable(byte_count) && $stable(status))
    else $error("result item changed while stalled");

  // Errors carry no bytes
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != a85dec_pkg::ST_OK |-> byte_count == 3'd0 && data_bytes == 32'd0)
    else $error("error item carries data");

  // Good items carry one to four bytes
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == a85dec_pkg::ST_OK |->
    byte_count == 3'd1 || byte_count == 3'd2 || byte_count == 3'd3 || byte_count == 3'd4)
    else $error("bad byte count on good item");

  // Bytes beyond the count are zero
  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_count == 3'd1 || byte_count == 3'd2 || byte_count == 3'd3) |->
    (byte_count == 3'd1 && data_bytes[23:0] == 24'd0) ||
    (byte_count == 3'd2 && data_bytes[15:0] == 16'd0) ||
    (byte_count == 3'd3 && data_bytes[7:0] == 8'd0))
    else $error("unused bytes not zero");

endmodule

bind ascii85_stream_decoder a85dec_checker u_a85dec_checker (.*);
